@@ design/hxp_pkg.sv @@
// hxp_pkg: shared types, mode and status codes, character helpers
// for the hex text parser; no dependencies
`timescale 1ns / 1ps

package hxp_pkg;

   localparam int ModeWidth = 3;

   localparam logic [ModeWidth-1:0] MODE_NORMAL  = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_HEX     = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_SLASH   = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_LINE    = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_BLOCK   = 3'd4;
   localparam logic [ModeWidth-1:0] MODE_STAR    = 3'd5;
   localparam logic [ModeWidth-1:0] MODE_LITERAL = 3'd6;
   localparam logic [ModeWidth-1:0] MODE_HALTED  = 3'd7;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_END  = 2'd2;

   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_STAR      = 8'h2a;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_CR        = 8'h0d;

   typedef logic [ModeWidth-1:0] mode_type;

   // parser state carried from word to word
   typedef struct packed {
      mode_type   mode;
      logic [3:0] high_nibble;
   } state_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       finished;
      logic [1:0] status;
   } rsp_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   // bit 4 set when c is not a hex digit, else the digit value
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h61 + 8'h0a;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h41 + 8'h0a;
      end
      return d[4:0];
   endfunction

endpackage

@@ design/hxp_if.sv @@
// hxp_if: valid/ready channel interfaces for request and response words
// does not import hxp_pkg; the field widths are written out here
`timescale 1ns / 1ps

interface hxp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface hxp_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] out_byte;
   logic       finished;
   logic [1:0] status;

   modport source (output valid, output byte_valid, output out_byte, output finished,
                   output status, input ready);
   modport sink   (input valid, input byte_valid, input out_byte, input finished,
                   input status, output ready);
endinterface

@@ design/hxp_decode.sv @@
// hxp_decode: one-word state transition and result of the hex text parser
// depends on hxp_pkg
`timescale 1ns / 1ps

module hxp_decode (
   input  hxp_pkg::state_type cur_state,
   input  hxp_pkg::req_type   word,
   output hxp_pkg::state_type next_state,
   output hxp_pkg::rsp_type   result
);
   import hxp_pkg::*;

   logic [4:0] digit;
   logic       is_digit;

   assign digit    = digit_value(word.char_in);
   assign is_digit = !digit[4];

   always_comb begin
      next_state = cur_state;
      result     = '0;
      if (word.end_of_input) begin
         result.finished = 1'b1;
         if (cur_state.mode == MODE_HEX || cur_state.mode == MODE_SLASH ||
             cur_state.mode == MODE_STAR || cur_state.mode == MODE_LITERAL) begin
            result.status = STATUS_BAD_END;
         end
         next_state.mode        = MODE_NORMAL;
         next_state.high_nibble = 4'h0;
      end else begin
         unique case (cur_state.mode)
            MODE_NORMAL: begin
               priority if (is_blank(word.char_in)) begin
                  next_state.mode = MODE_NORMAL;
               end else if (is_digit) begin
                  next_state.high_nibble = digit[3:0];
                  next_state.mode        = MODE_HEX;
               end else if (word.char_in == CHAR_BACKSLASH) begin
                  next_state.mode = MODE_LITERAL;
               end else if (word.char_in == CHAR_SLASH) begin
                  next_state.mode = MODE_SLASH;
               end else begin
                  result.status   = STATUS_BAD_CHAR;
                  next_state.mode = MODE_HALTED;
               end
            end
            MODE_HEX: begin
               if (is_digit) begin
                  result.byte_valid      = 1'b1;
                  result.out_byte        = {cur_state.high_nibble, digit[3:0]};
                  next_state.high_nibble = 4'h0;
                  next_state.mode        = MODE_NORMAL;
               end else begin
                  result.status   = STATUS_BAD_CHAR;
                  next_state.mode = MODE_HALTED;
               end
            end
            MODE_SLASH: begin
               priority if (word.char_in == CHAR_SLASH) begin
                  next_state.mode = MODE_LINE;
               end else if (word.char_in == CHAR_STAR) begin
                  next_state.mode = MODE_BLOCK;
               end else begin
                  result.status   = STATUS_BAD_CHAR;
                  next_state.mode = MODE_HALTED;
               end
            end
            MODE_LINE: begin
               if (word.char_in == CHAR_LF || word.char_in == CHAR_CR) begin
                  next_state.mode = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (word.char_in == CHAR_STAR) begin
                  next_state.mode = MODE_STAR;
               end
            end
            // any character but slash drops back into the block comment
            MODE_STAR: begin
               next_state.mode = (word.char_in == CHAR_SLASH) ? MODE_NORMAL : MODE_BLOCK;
            end
            MODE_LITERAL: begin
               result.byte_valid      = 1'b1;
               result.out_byte        = word.char_in;
               next_state.high_nibble = 4'h0;
               next_state.mode        = MODE_NORMAL;
            end
            MODE_HALTED: begin
               next_state.mode = MODE_HALTED;
            end
         endcase
      end
   end

endmodule

@@ design/hex_text_to_byte_parser_core.sv @@
// hex_text_to_byte_parser_core: input register, decode step, result register
// depends on hxp_pkg, hxp_if.sv and hxp_decode
// a req word is held in the input register, decoded, then held in the result register as rsp
// throughput: one word per cycle while rsp is not stalled; the mode update is a single decode step per word
// a stalled rsp holds its result; req keeps flowing while the input register can drain
// reset: synchronous active high, clears both stage valids, mode to normal, nibble to zero
`timescale 1ns / 1ps

module hex_text_to_byte_parser_core (
   input  logic clock,
   input  logic reset,
   hxp_req_if.sink   req_if,
   hxp_rsp_if.source rsp_if
);
   import hxp_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_word_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_word_ff;
   state_type state_ff;
   state_type next_state;
   rsp_type   step_result;
   logic      out_load;
   logic      in_load;

   hxp_decode u_decode (
      .cur_state  (state_ff),
      .word       (in_word_ff),
      .next_state (next_state),
      .result     (step_result)
   );

   // the state advances only when a word moves into the result register
   assign out_load      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || out_load;
   assign in_load       = req_if.valid && req_if.ready;
   assign in_valid_in   = in_load || (in_valid_ff && !out_load);
   assign out_valid_in  = out_load || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_NORMAL, high_nibble: 4'h0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            state_ff <= next_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_word_ff <= '{char_in: req_if.char_in, end_of_input: req_if.end_of_input};
      end
      if (out_load) begin
         out_word_ff <= step_result;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.byte_valid = out_word_ff.byte_valid;
   assign rsp_if.out_byte   = out_word_ff.out_byte;
   assign rsp_if.finished   = out_word_ff.finished;
   assign rsp_if.status     = out_word_ff.status;

   // a word that ended the stream leaves the parser in normal mode until drained
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.finished |->
         state_ff.mode == MODE_NORMAL && state_ff.high_nibble == 4'h0)
      else $error("end of input did not clear parser state");

   a_bad_char_halts: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.status == STATUS_BAD_CHAR |-> state_ff.mode == MODE_HALTED)
      else $error("unexpected character did not halt parser");

   a_byte_no_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.byte_valid |->
         out_word_ff.status == STATUS_OK && !out_word_ff.finished)
      else $error("byte produced together with error or end");

   a_state_only_on_load: assert property (@(posedge clock) disable iff (reset)
      !$past(out_load) && !$past(reset) |-> $stable(state_ff))
      else $error("parser state changed without a word moving");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
